>>> hw/rtl/truss_element_stiffness_defines.svh
// ----------------------------------------------------------------------------
// Truss element stiffness: assertion macros
// Shared property shorthands for the stiffness pipeline.
// ----------------------------------------------------------------------------
`ifndef TRUSS_ELEMENT_STIFFNESS_DEFINES_SVH
`define TRUSS_ELEMENT_STIFFNESS_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define TES_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define TES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/tes_pkg.sv
// ----------------------------------------------------------------------------
// Truss element stiffness package
// Widths, limits, lane indexes and the pipeline control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package tes_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int MOD_W   = 32;
  localparam int AREA_W  = 32;
  localparam int EA_W    = MOD_W + AREA_W;

  // squared direction cosine carries R_SHIFT fraction bits
  localparam int R_SHIFT = 62;
  localparam int R_W     = R_SHIFT + 1;

  localparam int TERM_W  = 64;
  localparam int QUO_W   = TERM_W;

  localparam int DIV_W_DEF  = 2 * COORD_WIDTH_DEF + 1;
  localparam int ROOT_W_DEF = COORD_WIDTH_DEF + 1;

  // lane order of the three stiffness terms
  localparam int LANE_XX = 0;
  localparam int LANE_XY = 1;
  localparam int LANE_YY = 2;
  localparam int NUM_LANES = 3;

  localparam logic [TERM_W-1:0] POS_LIMIT = {1'b0, {(TERM_W-1){1'b1}}};
  localparam logic [TERM_W-1:0] NEG_LIMIT = {1'b1, {(TERM_W-1){1'b0}}};

  // control bundle that travels beside the data
  typedef struct packed {
    logic valid;
    logic neg;
    logic zero;
  } ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/tes_mul.sv
// ----------------------------------------------------------------------------
// Split unsigned multiplier
// Four half-width partial products in one stage, their sum in the next.
// ----------------------------------------------------------------------------
`default_nettype none

module tes_mul #(
  parameter int AW = tes_pkg::EA_W,
  parameter int BW = tes_pkg::R_W
) (
  input  logic          clk,
  input  logic          en,
  input  logic [AW-1:0] a,
  input  logic [BW-1:0] b,
  output logic [AW+BW-1:0] p
);

  localparam int AL = (AW + 1) / 2;
  localparam int AH = AW - AL;
  localparam int BL = (BW + 1) / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic [AL+BL-1:0] p00_r;
  logic [AL+BH-1:0] p01_r;
  logic [AH+BL-1:0] p10_r;
  logic [AH+BH-1:0] p11_r;
  logic [PW-1:0]    p_r;
  logic [PW-1:0]    p_nxt;

  // partial products
  always_ff @(posedge clk) begin
    if (en) begin
      p00_r <= a[AL-1:0] * b[BL-1:0];
      p01_r <= a[AL-1:0] * b[BW-1:BL];
      p10_r <= a[AW-1:AL] * b[BL-1:0];
      p11_r <= a[AW-1:AL] * b[BW-1:BL];
    end
  end

  // recombine
  assign p_nxt = (PW'(p11_r) << (AL + BL)) + (PW'(p10_r) << AL)
               + (PW'(p01_r) << BL) + PW'(p00_r);

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire

>>> hw/rtl/tes_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Square root cell
// One result bit of a restoring integer square root per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module tes_sqrt_cell #(
  parameter int LW = tes_pkg::ROOT_W_DEF
) (
  input  logic            clk,
  input  logic            en,
  input  logic [LW+1:0]   rem_i,
  input  logic [LW-1:0]   root_i,
  input  logic [2*LW-1:0] rad_i,
  output logic [LW+1:0]   rem_o,
  output logic [LW-1:0]   root_o,
  output logic [2*LW-1:0] rad_o
);

  localparam int RMW = LW + 2;
  localparam int CW  = RMW + 2;

  logic [CW-1:0]   cur;
  logic [CW-1:0]   trial;
  logic            ge;
  logic [RMW-1:0]  rem_nxt;
  logic [LW-1:0]   root_nxt;
  logic [2*LW-1:0] rad_nxt;
  logic [RMW-1:0]  rem_r;
  logic [LW-1:0]   root_r;
  logic [2*LW-1:0] rad_r;

  // bring in two radicand bits, try root*4+1
  always_comb begin
    cur      = {rem_i, rad_i[2*LW-1 -: 2]};
    trial    = CW'({root_i, 2'b01});
    ge       = (cur >= trial);
    rem_nxt  = ge ? RMW'(cur - trial) : RMW'(cur);
    root_nxt = {root_i[LW-2:0], ge};
    rad_nxt  = {rad_i[2*LW-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      rad_r  <= rad_nxt;
    end
  end

  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign rad_o  = rad_r;

endmodule

`default_nettype wire

>>> hw/rtl/tes_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// One quotient bit of a restoring division per cell; the dividend bits
// still to come and the quotient so far shift along with the remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module tes_div_cell #(
  parameter int DVW = tes_pkg::DIV_W_DEF,
  parameter int NB  = tes_pkg::R_W
) (
  input  logic           clk,
  input  logic           en,
  input  logic [DVW-1:0] d,
  input  logic [DVW-1:0] rem_i,
  input  logic [NB-1:0]  num_i,
  input  logic [NB-1:0]  quo_i,
  output logic [DVW-1:0] rem_o,
  output logic [NB-1:0]  num_o,
  output logic [NB-1:0]  quo_o
);

  logic [DVW:0]   cur;
  logic [DVW:0]   dext;
  logic           ge;
  logic [DVW-1:0] rem_nxt;
  logic [NB-1:0]  num_nxt;
  logic [NB-1:0]  quo_nxt;
  logic [DVW-1:0] rem_r;
  logic [NB-1:0]  num_r;
  logic [NB-1:0]  quo_r;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    cur     = {rem_i, num_i[NB-1]};
    dext    = {1'b0, d};
    ge      = (cur >= dext);
    rem_nxt = ge ? DVW'(cur - dext) : DVW'(cur);
    num_nxt = {num_i[NB-2:0], 1'b0};
    quo_nxt = {quo_i[NB-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      num_r <= num_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign rem_o = rem_r;
  assign num_o = num_r;
  assign quo_o = quo_r;

endmodule

`default_nettype wire

>>> hw/rtl/truss_element_stiffness.sv
// ----------------------------------------------------------------------------
// Plane truss element stiffness terms
// Computes k*dx^2, k*dx*dy, k*dy^2 with k = E*A/l^3 for a 2-D bar element.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Handshake            Payload
// in_*     input      in_valid/in_ready    node coordinates, modulus, area
// out_*    output     out_valid/out_ready  three stiffness terms, two flags
//
// One item per cycle while no finished result waits at the output.
// The pipeline contains the 63-cell cosine divider chain and the 64-cell
// term divider chain; the square root runs beside the first chain.
// The whole pipeline advances together; it holds while a result waits.
// Reset clears the control bundles and output valid only; no memory, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "truss_element_stiffness_defines.svh"

module truss_element_stiffness #(
  parameter int COORD_WIDTH = tes_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = tes_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [COORD_WIDTH-1:0]      in_x_first,
  input  logic signed [COORD_WIDTH-1:0]      in_y_first,
  input  logic signed [COORD_WIDTH-1:0]      in_x_second,
  input  logic signed [COORD_WIDTH-1:0]      in_y_second,
  input  logic [tes_pkg::MOD_W-1:0]          in_modulus,
  input  logic [tes_pkg::AREA_W-1:0]         in_section_area,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [tes_pkg::TERM_W-1:0]  out_k_cos_cos,
  output logic signed [tes_pkg::TERM_W-1:0]  out_k_cos_sin,
  output logic signed [tes_pkg::TERM_W-1:0]  out_k_sin_sin,
  output logic                               out_zero_length,
  output logic                               out_saturated
);

  localparam int DW   = COORD_WIDTH + 1;
  localparam int MW   = COORD_WIDTH;
  localparam int PW   = 2 * COORD_WIDTH;
  localparam int QW   = PW + 1;
  localparam int LW   = COORD_WIDTH + 1;
  localparam int RADW = 2 * LW;
  localparam int RW   = tes_pkg::R_W;
  localparam int EW   = tes_pkg::EA_W;
  localparam int XW   = EW + RW;
  localparam int TSH  = tes_pkg::R_SHIFT - FRAC_BITS;
  localparam int TW   = XW - TSH;
  localparam int NQ   = tes_pkg::QUO_W;
  localparam int HT   = TW - NQ;
  localparam int HW   = (HT > LW) ? HT : LW;
  localparam int NL   = tes_pkg::NUM_LANES;
  localparam int LD   = RW - LW;
  localparam int TMW  = tes_pkg::TERM_W;

  logic en;
  logic acc;

  // control bundles
  tes_pkg::ctl_t ctl_a_r, ctl_b_r, ctl_m1_r, ctl_m2_r, ctl_x1_r, ctl_x2_r;
  tes_pkg::ctl_t rctl_r [RW+1];
  tes_pkg::ctl_t mctl_r [NQ+1];

  // front stages
  logic signed [DW-1:0]         dx_a_r, dy_a_r;
  logic [tes_pkg::MOD_W-1:0]    e_a_r, e_b_r;
  logic [tes_pkg::AREA_W-1:0]   ar_a_r, ar_b_r;
  logic [MW-1:0]                ax_b_r, ay_b_r;
  logic [MW-1:0]                ax_nxt, ay_nxt;
  logic [PW-1:0]                pxx_m, pxy_m, pyy_m;
  logic [EW-1:0]                ea_m;

  // cosine division stage
  logic [PW-1:0]  p_q_r [NL];
  logic [QW-1:0]  qd_r  [RW];
  logic [EW-1:0]  rea_r [RW+1];
  logic [QW-1:0]  rrem  [NL][RW+1];
  logic [RW-1:0]  rnum  [NL][RW+1];
  logic [RW-1:0]  rquo  [NL][RW+1];

  // square root chain
  logic [LW+1:0]   srem  [LW+1];
  logic [LW-1:0]   sroot [LW+1];
  logic [RADW-1:0] srad  [LW+1];
  logic [LW-1:0]   len_r [LD];
  logic [LW-1:0]   len_x1_r, len_x2_r;

  // term division stage
  logic [XW-1:0]  xprod  [NL];
  logic [HW-1:0]  t_hi   [NL];
  logic [NL-1:0]  ovf_nxt;
  logic [LW-1:0]  trem_r [NL];
  logic [NQ-1:0]  tnum_r [NL];
  logic [LW-1:0]  md_r   [NQ];
  logic [NL-1:0]  mov_r  [NQ+1];
  logic [LW-1:0]  mrem   [NL][NQ+1];
  logic [NQ-1:0]  mnum   [NL][NQ+1];
  logic [NQ-1:0]  mquo   [NL][NQ+1];

  // output stage
  logic           lane_neg [NL];
  logic [TMW-1:0] lim      [NL];
  logic [TMW-1:0] magc     [NL];
  logic [TMW-1:0] term_nxt [NL];
  logic [NL-1:0]  clip;
  logic           sat_nxt;
  logic           out_valid_r;
  logic [TMW-1:0] out_k_cos_cos_r, out_k_cos_sin_r, out_k_sin_sin_r;
  logic           out_zero_length_r, out_saturated_r;

  // handshake: pipeline moves unless a finished result is stuck
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;
  assign acc      = in_valid && en;

  // control flow through all stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r  <= '0;
      ctl_b_r  <= '0;
      ctl_m1_r <= '0;
      ctl_m2_r <= '0;
      ctl_x1_r <= '0;
      ctl_x2_r <= '0;
      for (int i = 0; i <= RW; i++) rctl_r[i] <= '0;
      for (int i = 0; i <= NQ; i++) mctl_r[i] <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      ctl_a_r  <= '{valid: acc, neg: 1'b0, zero: 1'b0};
      ctl_b_r  <= '{valid: ctl_a_r.valid, neg: dx_a_r[DW-1] ^ dy_a_r[DW-1], zero: 1'b0};
      ctl_m1_r <= ctl_b_r;
      ctl_m2_r <= ctl_m1_r;
      rctl_r[0] <= '{valid: ctl_m2_r.valid, neg: ctl_m2_r.neg,
                     zero: (pxx_m == '0) && (pyy_m == '0)};
      for (int i = 1; i <= RW; i++) rctl_r[i] <= rctl_r[i-1];
      ctl_x1_r <= rctl_r[RW];
      ctl_x2_r <= ctl_x1_r;
      mctl_r[0] <= ctl_x2_r;
      for (int i = 1; i <= NQ; i++) mctl_r[i] <= mctl_r[i-1];
      out_valid_r <= mctl_r[NQ].valid;
    end
  end

  // differences and magnitudes
  assign ax_nxt = dx_a_r[DW-1] ? MW'(-dx_a_r) : MW'(dx_a_r);
  assign ay_nxt = dy_a_r[DW-1] ? MW'(-dy_a_r) : MW'(dy_a_r);

  always_ff @(posedge clk) begin
    if (en) begin
      dx_a_r <= DW'(in_x_second) - DW'(in_x_first);
      dy_a_r <= DW'(in_y_second) - DW'(in_y_first);
      e_a_r  <= in_modulus;
      ar_a_r <= in_section_area;
      ax_b_r <= ax_nxt;
      ay_b_r <= ay_nxt;
      e_b_r  <= e_a_r;
      ar_b_r <= ar_a_r;
    end
  end

  // squares, cross product and E*A
  tes_mul #(.AW(MW), .BW(MW)) u_mul_xx (.clk(clk), .en(en), .a(ax_b_r), .b(ax_b_r), .p(pxx_m));
  tes_mul #(.AW(MW), .BW(MW)) u_mul_xy (.clk(clk), .en(en), .a(ax_b_r), .b(ay_b_r), .p(pxy_m));
  tes_mul #(.AW(MW), .BW(MW)) u_mul_yy (.clk(clk), .en(en), .a(ay_b_r), .b(ay_b_r), .p(pyy_m));
  tes_mul #(.AW(tes_pkg::MOD_W), .BW(tes_pkg::AREA_W)) u_mul_ea (
    .clk(clk), .en(en), .a(e_b_r), .b(ar_b_r), .p(ea_m)
  );

  // squared length and side data for the cosine chain
  always_ff @(posedge clk) begin
    if (en) begin
      p_q_r[tes_pkg::LANE_XX] <= pxx_m;
      p_q_r[tes_pkg::LANE_XY] <= pxy_m;
      p_q_r[tes_pkg::LANE_YY] <= pyy_m;
      qd_r[0]  <= QW'(pxx_m) + QW'(pyy_m);
      rea_r[0] <= ea_m;
      for (int i = 1; i < RW; i++) qd_r[i] <= qd_r[i-1];
      for (int i = 1; i <= RW; i++) rea_r[i] <= rea_r[i-1];
    end
  end

  // cosine chain: R = floor(P * 2^62 / Q), one bit per cell
  for (genvar l = 0; l < NL; l++) begin : g_rlane
    assign rrem[l][0] = QW'(p_q_r[l] >> 1);
    assign rnum[l][0] = {p_q_r[l][0], {(RW-1){1'b0}}};
    assign rquo[l][0] = '0;
    for (genvar i = 0; i < RW; i++) begin : g_rcell
      tes_div_cell #(.DVW(QW), .NB(RW)) u_cell (
        .clk(clk), .en(en), .d(qd_r[i]),
        .rem_i(rrem[l][i]), .num_i(rnum[l][i]), .quo_i(rquo[l][i]),
        .rem_o(rrem[l][i+1]), .num_o(rnum[l][i+1]), .quo_o(rquo[l][i+1])
      );
    end
  end

  // length chain, fed with Q beside the cosine chain
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign srad[0]  = RADW'(qd_r[0]);

  for (genvar i = 0; i < LW; i++) begin : g_sqrt
    tes_sqrt_cell #(.LW(LW)) u_cell (
      .clk(clk), .en(en),
      .rem_i(srem[i]), .root_i(sroot[i]), .rad_i(srad[i]),
      .rem_o(srem[i+1]), .root_o(sroot[i+1]), .rad_o(srad[i+1])
    );
  end

  // align the length with the end of the cosine chain
  always_ff @(posedge clk) begin
    if (en) begin
      len_r[0] <= sroot[LW];
      for (int i = 1; i < LD; i++) len_r[i] <= len_r[i-1];
      len_x1_r <= len_r[LD-1];
      len_x2_r <= len_x1_r;
    end
  end

  // E*A times the squared cosines
  for (genvar l = 0; l < NL; l++) begin : g_xmul
    tes_mul #(.AW(EW), .BW(RW)) u_mul (
      .clk(clk), .en(en), .a(rea_r[RW]), .b(rquo[l][RW]), .p(xprod[l])
    );
  end

  // scale, early overflow check against the length
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      t_hi[l]    = HW'(xprod[l][XW-1:NQ+TSH]);
      ovf_nxt[l] = (t_hi[l] >= HW'(len_x2_r));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NL; l++) begin
        trem_r[l] <= t_hi[l][LW-1:0];
        tnum_r[l] <= xprod[l][NQ+TSH-1:TSH];
      end
      mov_r[0] <= ovf_nxt;
      md_r[0]  <= len_x2_r;
      for (int i = 1; i <= NQ; i++) mov_r[i] <= mov_r[i-1];
      for (int i = 1; i < NQ; i++) md_r[i] <= md_r[i-1];
    end
  end

  // term chain: M = floor(T / L), one bit per cell
  for (genvar l = 0; l < NL; l++) begin : g_mlane
    assign mrem[l][0] = trem_r[l];
    assign mnum[l][0] = tnum_r[l];
    assign mquo[l][0] = '0;
    for (genvar i = 0; i < NQ; i++) begin : g_mcell
      tes_div_cell #(.DVW(LW), .NB(NQ)) u_cell (
        .clk(clk), .en(en), .d(md_r[i]),
        .rem_i(mrem[l][i]), .num_i(mnum[l][i]), .quo_i(mquo[l][i]),
        .rem_o(mrem[l][i+1]), .num_o(mnum[l][i+1]), .quo_o(mquo[l][i+1])
      );
    end
  end

  // sign, saturation and the coincident-node case
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      lane_neg[l] = (l == tes_pkg::LANE_XY) ? mctl_r[NQ].neg : 1'b0;
      lim[l]      = lane_neg[l] ? tes_pkg::NEG_LIMIT : tes_pkg::POS_LIMIT;
      clip[l]     = mov_r[NQ][l] || (mquo[l][NQ] > lim[l]);
      magc[l]     = clip[l] ? lim[l] : mquo[l][NQ];
      if (mctl_r[NQ].zero) begin
        term_nxt[l] = '0;
      end else if (lane_neg[l]) begin
        term_nxt[l] = TMW'(0) - magc[l];
      end else begin
        term_nxt[l] = magc[l];
      end
    end
    sat_nxt = (|clip) && !mctl_r[NQ].zero;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_k_cos_cos_r   <= term_nxt[tes_pkg::LANE_XX];
      out_k_cos_sin_r   <= term_nxt[tes_pkg::LANE_XY];
      out_k_sin_sin_r   <= term_nxt[tes_pkg::LANE_YY];
      out_zero_length_r <= mctl_r[NQ].zero;
      out_saturated_r   <= sat_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_k_cos_cos   = $signed(out_k_cos_cos_r);
  assign out_k_cos_sin   = $signed(out_k_cos_sin_r);
  assign out_k_sin_sin   = $signed(out_k_sin_sin_r);
  assign out_zero_length = out_zero_length_r;
  assign out_saturated   = out_saturated_r;

  // checks
  `TES_ASSERT_NOW(a_zero_len_clears, clk, rst_n, out_valid_r && out_zero_length_r, (out_k_cos_cos_r == '0) && (out_k_cos_sin_r == '0) && (out_k_sin_sin_r == '0) && !out_saturated_r, "coincident nodes gave nonzero terms")
  `TES_ASSERT_NOW(a_diag_nonneg, clk, rst_n, out_valid_r, !out_k_cos_cos_r[TMW-1] && !out_k_sin_sin_r[TMW-1], "diagonal term came out negative")
  `TES_ASSERT_NEXT(a_chain_holds, clk, rst_n, !en, $stable(mctl_r[NQ]) && $stable(mov_r[NQ]), "term chain moved during a stall")
  `TES_ASSERT_NEXT(a_result_lands, clk, rst_n, en && mctl_r[NQ].valid, out_valid_r, "finished item did not reach the output")

endmodule

`default_nettype wire

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// Truss element stiffness testbench
// Sends element items through the valid/ready input channel and checks each
// result, field by field, against a bit-exact integer predictor kept here.
// Directed corner cases come first, then random elements with random idling
// on both sides, a long receiver hold-off, a full drain and an idle-free tail.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int CW         = tes_pkg::COORD_WIDTH_DEF;
  localparam int FB         = tes_pkg::FRAC_BITS_DEF;
  localparam int TW         = tes_pkg::TERM_W;
  localparam int LATENCY    = 136;
  localparam int WDOG_LIMIT = 3000;
  localparam int HOLD_LEN   = 400;

  typedef struct {
    logic [TW-1:0] cc;
    logic [TW-1:0] cs;
    logic [TW-1:0] ss;
    logic          zero_len;
    logic          sat;
  } stiff_terms_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [CW-1:0] in_x_first;
  logic signed [CW-1:0] in_y_first;
  logic signed [CW-1:0] in_x_second;
  logic signed [CW-1:0] in_y_second;
  logic [tes_pkg::MOD_W-1:0]  in_modulus;
  logic [tes_pkg::AREA_W-1:0] in_section_area;
  logic out_valid;
  logic out_ready;
  logic signed [TW-1:0] out_k_cos_cos;
  logic signed [TW-1:0] out_k_cos_sin;
  logic signed [TW-1:0] out_k_sin_sin;
  logic out_zero_length;
  logic out_saturated;

  stiff_terms_t pending_terms[$];
  int  error_count;
  bit  sender_idle_en;
  bit  sink_idle_en;
  bit  hold_req;
  int  quiet_cycles;

  truss_element_stiffness dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_x_first      (in_x_first),
    .in_y_first      (in_y_first),
    .in_x_second     (in_x_second),
    .in_y_second     (in_y_second),
    .in_modulus      (in_modulus),
    .in_section_area (in_section_area),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_k_cos_cos   (out_k_cos_cos),
    .out_k_cos_sin   (out_k_cos_sin),
    .out_k_sin_sin   (out_k_sin_sin),
    .out_zero_length (out_zero_length),
    .out_saturated   (out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // integer square root, floor
  function automatic logic [63:0] isqrt_len(input logic [67:0] q);
    logic [79:0] root;
    logic [79:0] cand;
    root = '0;
    for (int i = 34; i >= 0; i--) begin
      cand = root | (80'd1 << i);
      if (cand * cand <= {12'd0, q}) root = cand;
    end
    return root[63:0];
  endfunction

  // one stiffness term: EA * (P/Q) / L, magnitudes truncated, then clipped
  function automatic logic [TW-1:0] stiff_term(input logic [63:0] ea, input logic [67:0] p,
                                               input logic [67:0] q, input logic [63:0] len,
                                               input bit neg, inout logic sat);
    logic [135:0] cos2;
    logic [135:0] prod;
    logic [135:0] mag;
    logic [135:0] limit;
    cos2  = ({68'd0, p} << tes_pkg::R_SHIFT) / {68'd0, q};
    prod  = {72'd0, ea} * {73'd0, cos2[62:0]};
    mag   = (prod >> (tes_pkg::R_SHIFT - FB)) / {72'd0, len};
    limit = neg ? (136'd1 << 63) : ((136'd1 << 63) - 1);
    if (mag > limit) begin
      mag = limit;
      sat = 1'b1;
    end
    return neg ? (64'd0 - mag[63:0]) : mag[63:0];
  endfunction

  function automatic stiff_terms_t predict_stiffness(
      input logic [CW-1:0] x1, input logic [CW-1:0] y1,
      input logic [CW-1:0] x2, input logic [CW-1:0] y2,
      input logic [31:0] modulus, input logic [31:0] area);
    logic signed [CW:0] dx;
    logic signed [CW:0] dy;
    logic [67:0] ax;
    logic [67:0] ay;
    logic [67:0] q;
    logic [63:0] ea;
    logic [63:0] len;
    stiff_terms_t r;
    dx = $signed({x2[CW-1], x2}) - $signed({x1[CW-1], x1});
    dy = $signed({y2[CW-1], y2}) - $signed({y1[CW-1], y1});
    ax = dx < 0 ? 68'(-dx) : 68'(dx);
    ay = dy < 0 ? 68'(-dy) : 68'(dy);
    ea = 64'(modulus) * 64'(area);
    q  = ax * ax + ay * ay;
    r.sat = 1'b0;
    if (q == 0) begin
      r.cc = '0; r.cs = '0; r.ss = '0; r.zero_len = 1'b1;
      return r;
    end
    len = isqrt_len(q);
    r.zero_len = 1'b0;
    r.cc = stiff_term(ea, ax * ax, q, len, 1'b0, r.sat);
    r.cs = stiff_term(ea, ax * ay, q, len, (dx < 0) != (dy < 0), r.sat);
    r.ss = stiff_term(ea, ay * ay, q, len, 1'b0, r.sat);
    return r;
  endfunction

  // send one element; valid stays high after the transfer
  task automatic send_element(input logic [CW-1:0] x1, input logic [CW-1:0] y1,
                              input logic [CW-1:0] x2, input logic [CW-1:0] y2,
                              input logic [31:0] modulus, input logic [31:0] area);
    int gap;
    gap = 0;
    if (sender_idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_x_first      <= x1;
    in_y_first      <= y1;
    in_x_second     <= x2;
    in_y_second     <= y2;
    in_modulus      <= modulus;
    in_section_area <= area;
    do @(posedge clk); while (!in_ready);
    pending_terms.push_back(predict_stiffness(x1, y1, x2, y2, modulus, area));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_terms.size() != 0) @(posedge clk);
  endtask

  // random element; mostly moderate sizes so that results are not all clipped
  task automatic send_random_element();
    logic [CW-1:0] x1, y1;
    logic [31:0] dxr, dyr, modulus, area;
    x1 = $urandom();
    y1 = $urandom();
    case ($urandom_range(0, 3))
      0: begin dxr = $urandom(); dyr = $urandom(); end
      1: begin dxr = $urandom() >> $urandom_range(0, 31); dyr = $urandom() >> $urandom_range(0, 31); end
      2: begin dxr = $urandom_range(0, 3) - 1; dyr = $urandom() >> $urandom_range(8, 24); end
      default: begin dxr = $urandom() >> $urandom_range(8, 24); dyr = $urandom_range(0, 2) - 1; end
    endcase
    modulus = $urandom() >> $urandom_range(0, 31);
    area    = $urandom() >> $urandom_range(0, 31);
    if ($urandom_range(0, 19) == 0) modulus = '0;
    if ($urandom_range(0, 19) == 0) dxr = '0;
    if ($urandom_range(0, 1) == 0) send_element(x1, y1, x1 + dxr, y1 + dyr, modulus, area);
    else send_element($urandom(), $urandom(), $urandom(), $urandom(), modulus, area);
  endtask

  task automatic test_corner_cases();
    logic [CW-1:0] cmin, cmax;
    cmin = {1'b1, {(CW-1){1'b0}}};
    cmax = {1'b0, {(CW-1){1'b1}}};
    // coincident nodes, zero modulus, zero area
    send_element(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000, 32'd200, 32'h0001_0000);
    send_element(cmin, cmax, cmin, cmax, '1, '1);
    send_element(0, 0, 32'h0003_0000, 32'h0004_0000, 32'd0, 32'h0001_0000);
    send_element(0, 0, 32'h0003_0000, 32'h0004_0000, 32'd1000, 32'd0);
    // the four quadrants, sine keeps its sign
    send_element(0, 0, 32'h0003_0000, 32'h0004_0000, 32'd1000, 32'h0001_0000);
    send_element(0, 0, 32'hFFFD_0000, 32'h0004_0000, 32'd1000, 32'h0001_0000);
    send_element(0, 0, 32'h0003_0000, 32'hFFFC_0000, 32'd1000, 32'h0001_0000);
    send_element(0, 0, 32'hFFFD_0000, 32'hFFFC_0000, 32'd1000, 32'h0001_0000);
    // axis aligned bars
    send_element(0, 0, 32'h0005_0000, 0, 32'd7, 32'h0002_8000);
    send_element(0, 0, 0, 32'hFFFB_0000, 32'd7, 32'h0002_8000);
    // extreme spans and smallest spans
    send_element(cmin, cmin, cmax, cmax, '1, '1);
    send_element(cmax, cmin, cmin, cmax, '1, '1);
    send_element(cmin, cmin, cmax, cmax, 32'd1, 32'd1);
    send_element(0, 0, 32'd1, 0, '1, '1);
    send_element(0, 0, 32'd1, 32'd1, '1, '1);
    send_element(0, 0, 32'hFFFF_FFFF, 32'd1, '1, '1);
    send_element(cmax, cmax, cmax - 1, cmax, '1, 32'd1);
    send_element(cmin, 0, cmax, 32'd1, 32'h8000_0000, 32'h8000_0000);
    send_element(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                 32'h5555_5555, 32'hAAAA_AAAA);
  endtask

  task automatic test_random_traffic(input int count);
    repeat (count) send_random_element();
  endtask

  // receiver holds off while items keep coming, so the pipeline fills;
  // the receiver takes the request down when it starts the hold-off
  task automatic test_output_backpressure();
    hold_req <= 1'b1;
    repeat (200) send_random_element();
  endtask

  task automatic test_drain_pause();
    repeat (20) send_random_element();
    wait_drained();
    repeat (20) send_random_element();
  endtask

  // receiver side: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  <= 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        out_ready <= 1'b1;
      end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 6);
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    stiff_terms_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_terms.size() == 0) begin
        $display("%0t: unexpected result transfer", $time);
        error_count++;
      end else begin
        want = pending_terms.pop_front();
        if (out_k_cos_cos !== want.cc) begin
          $display("%0t: k_cos_cos exp %h got %h", $time, want.cc, out_k_cos_cos);
          error_count++;
        end
        if (out_k_cos_sin !== want.cs) begin
          $display("%0t: k_cos_sin exp %h got %h", $time, want.cs, out_k_cos_sin);
          error_count++;
        end
        if (out_k_sin_sin !== want.ss) begin
          $display("%0t: k_sin_sin exp %h got %h", $time, want.ss, out_k_sin_sin);
          error_count++;
        end
        if (out_zero_length !== want.zero_len) begin
          $display("%0t: zero_length exp %b got %b", $time, want.zero_len, out_zero_length);
          error_count++;
        end
        if (out_saturated !== want.sat) begin
          $display("%0t: saturated exp %b got %b", $time, want.sat, out_saturated);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    error_count    = 0;
    quiet_cycles   = 0;
    sender_idle_en = 1'b1;
    sink_idle_en   = 1'b1;
    hold_req       = 1'b0;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_x_first      <= '0;
    in_y_first      <= '0;
    in_x_second     <= '0;
    in_y_second     <= '0;
    in_modulus      <= '0;
    in_section_area <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corner_cases();
    test_random_traffic(120);
    test_output_backpressure();
    test_drain_pause();
    // tail without idling on either side
    sender_idle_en = 1'b0;
    sink_idle_en   = 1'b0;
    test_random_traffic(70);

    wait_drained();
    repeat (LATENCY + 20) @(posedge clk);
    if (error_count == 0 && pending_terms.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> truss_element_stiffness.f
+incdir+hw/rtl
hw/rtl/tes_pkg.sv
hw/rtl/tes_mul.sv
hw/rtl/tes_sqrt_cell.sv
hw/rtl/tes_div_cell.sv
hw/rtl/truss_element_stiffness.sv
verif/tb.sv
